/* sv/i2r_pkg.sv */
package i2r_pkg;

	// Accepted input range is 1 .. MaxValid
	localparam int ValueWidth  = 12;
	localparam int SymbolWidth = 8;
	localparam int MaxValid    = 3999;

	// Decimal place weights
	localparam int DecThousand = 1000;
	localparam int DecHundred  = 100;
	localparam int DecTen      = 10;

	// ASCII letters
	localparam logic [SymbolWidth-1:0] ChrI = 8'h49;
	localparam logic [SymbolWidth-1:0] ChrV = 8'h56;
	localparam logic [SymbolWidth-1:0] ChrX = 8'h58;
	localparam logic [SymbolWidth-1:0] ChrL = 8'h4C;
	localparam logic [SymbolWidth-1:0] ChrC = 8'h43;
	localparam logic [SymbolWidth-1:0] ChrD = 8'h44;
	localparam logic [SymbolWidth-1:0] ChrM = 8'h4D;
	localparam logic [SymbolWidth-1:0] ChrNone = 8'h00;

	// Letter role inside one decimal digit
	typedef enum logic [1:0] {
		CODE_END  = 2'd0,
		CODE_ONE  = 2'd1,
		CODE_FIVE = 2'd2,
		CODE_TEN  = 2'd3
	} code_t;

	// Decimal place index: 0 = units ... 3 = thousands
	typedef logic [1:0] place_t;

	// One split value handed to the emitter
	typedef struct packed {
		logic             err;
		logic [3:0][3:0]  dig;
	} i2r_item_t;

	// Result of a search for a nonzero digit
	typedef struct packed {
		logic   found;
		place_t place;
	} place_hit_t;

	// Letter role of step k of decimal digit d
	function automatic code_t pat_code(input logic [3:0] d, input logic [1:0] k);
		logic [7:0] row;
		// k = 0 sits in the low two bits
		case (d)
			4'd1:    row = {CODE_END, CODE_END, CODE_END, CODE_ONE};
			4'd2:    row = {CODE_END, CODE_END, CODE_ONE, CODE_ONE};
			4'd3:    row = {CODE_END, CODE_ONE, CODE_ONE, CODE_ONE};
			4'd4:    row = {CODE_END, CODE_END, CODE_FIVE, CODE_ONE};
			4'd5:    row = {CODE_END, CODE_END, CODE_END, CODE_FIVE};
			4'd6:    row = {CODE_END, CODE_END, CODE_ONE, CODE_FIVE};
			4'd7:    row = {CODE_END, CODE_ONE, CODE_ONE, CODE_FIVE};
			4'd8:    row = {CODE_ONE, CODE_ONE, CODE_ONE, CODE_FIVE};
			4'd9:    row = {CODE_END, CODE_END, CODE_TEN, CODE_ONE};
			default: row = '0;
		endcase
		return code_t'(row[{k, 1'b0} +: 2]);
	endfunction

	// ASCII letter for a role at a decimal place
	function automatic logic [SymbolWidth-1:0] place_letter(input place_t p, input code_t c);
		logic [SymbolWidth-1:0] ch;
		ch = ChrNone;
		unique case (p)
			2'd0: begin
				case (c)
					CODE_ONE:  ch = ChrI;
					CODE_FIVE: ch = ChrV;
					CODE_TEN:  ch = ChrX;
					default:   ch = ChrNone;
				endcase
			end
			2'd1: begin
				case (c)
					CODE_ONE:  ch = ChrX;
					CODE_FIVE: ch = ChrL;
					CODE_TEN:  ch = ChrC;
					default:   ch = ChrNone;
				endcase
			end
			2'd2: begin
				case (c)
					CODE_ONE:  ch = ChrC;
					CODE_FIVE: ch = ChrD;
					CODE_TEN:  ch = ChrM;
					default:   ch = ChrNone;
				endcase
			end
			default: begin
				ch = (c == CODE_ONE) ? ChrM : ChrNone;
			end
		endcase
		return ch;
	endfunction

	// Highest nonzero digit strictly below place p
	function automatic place_hit_t lower_nonzero(input logic [3:0][3:0] dig, input place_t p);
		place_hit_t hit;
		hit = '0;
		for (int i = 0; i < 3; i++) begin
			if (i < int'(p) && dig[i] != 4'd0) begin
				hit.found = 1'b1;
				hit.place = place_t'(i);
			end
		end
		return hit;
	endfunction

	// Highest nonzero digit overall
	function automatic place_t top_nonzero(input logic [3:0][3:0] dig);
		place_t p;
		p = '0;
		for (int i = 0; i < 4; i++) begin
			if (dig[i] != 4'd0) begin
				p = place_t'(i);
			end
		end
		return p;
	endfunction

endpackage

/* sv/i2r_split.sv */
module i2r_split
	import i2r_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ValueWidth-1:0] value,
	output logic                  item_valid,
	input  logic                  item_ready,
	output i2r_item_t             item
);

	// Stage registers
	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic [ValueWidth-1:0] value_s1;
	logic                  err_s2, err_s3;
	logic [1:0]            th_s2, th_s3;
	logic [9:0]            rem_s2;
	logic [3:0]            hun_s3;
	logic [6:0]            rem_s3;
	i2r_item_t             item_s4;

	logic en_s1, en_s2, en_s3, en_s4;

	// Stage enables: a stage loads when empty or when its content moves on
	assign en_s4 = !vld_s4 || item_ready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Thousands digit and range check
	logic                  err_c;
	logic [1:0]            th_c;
	logic [9:0]            rem1_c;
	always_comb begin
		err_c = (value_s1 == '0) || (value_s1 > ValueWidth'(MaxValid));
		if (value_s1 >= ValueWidth'(3 * DecThousand))
			th_c = 2'd3;
		else if (value_s1 >= ValueWidth'(2 * DecThousand))
			th_c = 2'd2;
		else if (value_s1 >= ValueWidth'(DecThousand))
			th_c = 2'd1;
		else
			th_c = 2'd0;
		rem1_c = 10'(value_s1 - ValueWidth'(th_c) * ValueWidth'(DecThousand));
	end

	// Hundreds digit
	logic [3:0] hun_c;
	logic [6:0] rem2_c;
	always_comb begin
		hun_c = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (rem_s2 >= 10'(i * DecHundred))
				hun_c = 4'(i);
		end
		rem2_c = 7'(rem_s2 - 10'(hun_c) * 10'(DecHundred));
	end

	// Tens and units digits
	logic [3:0] ten_c;
	logic [3:0] one_c;
	always_comb begin
		ten_c = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (rem_s3 >= 7'(i * DecTen))
				ten_c = 4'(i);
		end
		one_c = 4'(rem_s3 - 7'(ten_c) * 7'(DecTen));
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			value_s1 <= value;
		end
		if (en_s2 && vld_s1) begin
			err_s2 <= err_c;
			th_s2  <= th_c;
			rem_s2 <= rem1_c;
		end
		if (en_s3 && vld_s2) begin
			err_s3 <= err_s2;
			th_s3  <= th_s2;
			hun_s3 <= hun_c;
			rem_s3 <= rem2_c;
		end
		if (en_s4 && vld_s3) begin
			item_s4.err    <= err_s3;
			item_s4.dig[3] <= {2'b00, th_s3};
			item_s4.dig[2] <= hun_s3;
			item_s4.dig[1] <= ten_c;
			item_s4.dig[0] <= one_c;
		end
	end

	assign item_valid = vld_s4;
	assign item       = item_s4;

endmodule

/* sv/i2r_emit.sv */
module i2r_emit
	import i2r_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  i2r_item_t              item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SymbolWidth-1:0] symbol,
	output logic                   last,
	output logic                   error
);

	// Walk state over the current value
	logic            busy_q;
	logic            err_q;
	logic [3:0][3:0] dig_q;
	place_t          place_q;
	logic [1:0]      k_q;

	// Output register
	logic                   out_valid_q;
	logic [SymbolWidth-1:0] symbol_q;
	logic                   last_q;
	logic                   error_q;

	// Current character
	logic [3:0]             cur_dig;
	code_t                  cur_code;
	logic                   k_last;
	place_hit_t             nxt;
	logic                   cur_last;
	logic [SymbolWidth-1:0] cur_sym;
	logic                   out_load;

	always_comb begin
		cur_dig  = dig_q[place_q];
		cur_code = pat_code(cur_dig, k_q);
		k_last   = (k_q == 2'd3) || (pat_code(cur_dig, k_q + 2'd1) == CODE_END);
		nxt      = lower_nonzero(dig_q, place_q);
		cur_last = err_q || (k_last && !nxt.found);
		cur_sym  = err_q ? ChrNone : place_letter(place_q, cur_code);
	end

	assign out_load   = busy_q && (!out_valid_q || out_ready);
	assign item_ready = !busy_q || (out_load && cur_last);

	// Busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (item_ready) begin
			busy_q <= item_valid;
		end
	end

	// Walk position: load a new value or step to the next letter
	always_ff @(posedge clk) begin
		if (item_ready) begin
			if (item_valid) begin
				err_q   <= item.err;
				dig_q   <= item.dig;
				place_q <= top_nonzero(item.dig);
				k_q     <= 2'd0;
			end
		end else if (out_load) begin
			if (k_last) begin
				place_q <= nxt.place;
				k_q     <= 2'd0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			symbol_q <= cur_sym;
			last_q   <= cur_last;
			error_q  <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign error     = error_q;

	// An error transaction is a lone zero character
	a_err_lone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && symbol == ChrNone)
		else $error("error transaction without last or with a letter");

	// A numeral letter is never zero
	a_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> symbol != ChrNone)
		else $error("zero symbol inside a numeral");

	// The next letter of a numeral follows without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a numeral");

	// A new value is not taken while a numeral is still mid-walk
	a_no_cut: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && item_ready |-> out_load && cur_last)
		else $error("new value taken before the numeral ended");

endmodule

/* sv/integer_to_roman_numeral_top.sv */
// Integer to Roman numeral converter. Each input transaction carries a 12-bit
// value; the block returns its Roman numeral (I V X L C D M with the
// subtractive forms IV IX XL XC CD CM) as one output transaction per ASCII
// letter, most significant letter first, with last set on the final letter.
// Values of 0 or above 3999 give one transaction with symbol 0, last 1 and
// error 1. A numeral has 1 to 15 letters (15 for 3888). The output register,
// at one letter per cycle while out_ready is held, sets the sustained rate.
// Inputs are taken every cycle, unless the pipeline is full, into a
// four-stage digit split pipeline while earlier numerals are still being
// sent, so numerals follow each other without a gap. Each value passes the
// four split stages, the walk state and the output register before its first
// letter appears. No configuration; reset only clears the valid and busy flags.
module integer_to_roman_numeral_top
	import i2r_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ValueWidth-1:0]  value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SymbolWidth-1:0] symbol,
	output logic                   last,
	output logic                   error
);

	logic      item_valid;
	logic      item_ready;
	i2r_item_t item;

	// Decimal digit split
	i2r_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// Letter walk and output register
	i2r_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.last       (last),
		.error      (error)
	);

endmodule

/* test/tb_integer_to_roman_numeral_top.sv */
module tb_integer_to_roman_numeral_top;
	import i2r_pkg::*;

	// One letter of a numeral as it leaves the block
	typedef struct packed {
		logic [SymbolWidth-1:0] symbol;
		logic                   last;
		logic                   error;
	} letter_t;

	// One input transaction; a typed numeral or error flag overrides the predictor
	typedef struct {
		logic [ValueWidth-1:0] value;
		bit                    is_err;
		string                 numeral;
	} value_row_t;

	localparam int NumDirected = 24;
	localparam int NumRandom   = 76;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [ValueWidth-1:0]  value     = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SymbolWidth-1:0] symbol;
	logic                   last;
	logic                   error;

	letter_t    numeral_q[$];
	value_row_t pending_q[$];
	int         mismatch_count = 0;
	int         values_taken   = 0;
	int         letters_seen   = 0;
	int         bad_values     = 0;

	value_row_t directed_rows[NumDirected] = '{
		'{12'd0,    1'b1, ""},
		'{12'd4095, 1'b1, ""},
		'{12'd4000, 1'b1, ""},
		'{12'd1,    1'b0, "I"},
		'{12'd3999, 1'b0, "MMMCMXCIX"},
		'{12'd3888, 1'b0, "MMMDCCCLXXXVIII"},
		'{12'd4,    1'b0, "IV"},
		'{12'd9,    1'b0, "IX"},
		'{12'd40,   1'b0, "XL"},
		'{12'd90,   1'b0, "XC"},
		'{12'd400,  1'b0, "CD"},
		'{12'd900,  1'b0, "CM"},
		'{12'd3,    1'b0, ""},
		'{12'd5,    1'b0, ""},
		'{12'd8,    1'b0, ""},
		'{12'd10,   1'b0, ""},
		'{12'd50,   1'b0, ""},
		'{12'd100,  1'b0, ""},
		'{12'd500,  1'b0, ""},
		'{12'd1000, 1'b0, ""},
		'{12'd1994, 1'b0, ""},
		'{12'd2048, 1'b0, ""},
		'{12'd2730, 1'b0, ""},
		'{12'd1365, 1'b0, ""}
	};

	integer_to_roman_numeral_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.last      (last),
		.error     (error)
	);

	always #6 clk = ~clk;

	// Run limit well above the slowest legal run
	initial begin
		#(12 * 400000);
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH t=%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Expected letters of one value, most significant first
	function automatic void predict_numeral(input logic [ValueWidth-1:0] v);
		logic [SymbolWidth-1:0] unit_chr[4];
		logic [SymbolWidth-1:0] five_chr[3];
		logic [SymbolWidth-1:0] letters[$];
		int                     digit;
		int                     rest;
		unit_chr = '{ChrI, ChrX, ChrC, ChrM};
		five_chr = '{ChrV, ChrL, ChrD};
		if (v == 0 || int'(v) > MaxValid) begin
			numeral_q.push_back('{ChrNone, 1'b1, 1'b1});
			return;
		end
		rest = int'(v);
		for (int p = 3; p >= 0; p--) begin
			digit = (rest / (10 ** p)) % 10;
			case (digit)
				1, 2, 3: begin
					repeat (digit) letters.push_back(unit_chr[p]);
				end
				4: begin
					letters.push_back(unit_chr[p]);
					letters.push_back(five_chr[p]);
				end
				5, 6, 7, 8: begin
					letters.push_back(five_chr[p]);
					repeat (digit - 5) letters.push_back(unit_chr[p]);
				end
				9: begin
					letters.push_back(unit_chr[p]);
					letters.push_back(unit_chr[p+1]);
				end
				default: ;
			endcase
		end
		foreach (letters[i])
			numeral_q.push_back('{letters[i], i == letters.size() - 1, 1'b0});
	endfunction

	// Expectations of a row whose result is typed into the table
	function automatic void push_typed(input value_row_t row);
		if (row.is_err) begin
			numeral_q.push_back('{ChrNone, 1'b1, 1'b1});
		end else begin
			for (int i = 0; i < row.numeral.len(); i++)
				numeral_q.push_back('{row.numeral[i], i == row.numeral.len() - 1, 1'b0});
		end
	endfunction

	// Accepted inputs feed the expectations; accepted letters are checked
	always @(posedge clk) begin
		value_row_t row;
		letter_t    exp_letter;
		if (arst_n && in_valid && in_ready) begin
			row = pending_q.pop_front();
			values_taken++;
			if (value == 0 || int'(value) > MaxValid)
				bad_values++;
			if (row.is_err || row.numeral.len() != 0)
				push_typed(row);
			else
				predict_numeral(value);
		end
		if (arst_n && out_valid && out_ready) begin
			letters_seen++;
			if (numeral_q.size() == 0) begin
				report_mismatch($sformatf("unexpected letter %h last=%b error=%b",
					symbol, last, error));
			end else begin
				exp_letter = numeral_q.pop_front();
				if (symbol !== exp_letter.symbol)
					report_mismatch($sformatf("symbol %h, want %h", symbol, exp_letter.symbol));
				if (last !== exp_letter.last)
					report_mismatch($sformatf("last %b, want %b", last, exp_letter.last));
				if (error !== exp_letter.error)
					report_mismatch($sformatf("error %b, want %b", error, exp_letter.error));
			end
		end
	end

	// Receiver: runs of ready, mostly short stalls with a few long ones
	initial begin
		int hold;
		int stall;
		forever begin
			hold  = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80)
				: $urandom_range(1, 6);
			stall = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 40)
				: $urandom_range(1, 3);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ValueWidth-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return ($urandom_range(0, 3) == 0) ? 12'd0 : ValueWidth'($urandom_range(4000, 4095));
		else if (r < 16)
			return ValueWidth'($urandom_range(0, 4095));
		else if (r < 24)
			return ($urandom_range(0, 1) == 1) ? 12'd3888 : ValueWidth'($urandom_range(3800, 3999));
		return ValueWidth'($urandom_range(1, MaxValid));
	endfunction

	// Present one transaction and return at the edge that takes it
	task automatic send_value(input value_row_t row, input int gap);
		pending_q.push_back(row);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= row.value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		// Let the expectations of the last accepted transaction land first
		@(posedge clk);
		while (numeral_q.size() != 0) @(posedge clk);
	endtask

	// Sender
	initial begin
		value_row_t row;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_value(directed_rows[i], pick_gap());
		wait_drained();

		for (int n = 0; n < NumRandom; n++) begin
			row = '{pick_value(), 1'b0, ""};
			// Burst with no gaps for a stretch in the middle
			send_value(row, (n >= 20 && n < 35) ? 0 : pick_gap());
			if (n == NumRandom / 2)
				wait_drained();
		end
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Converted %0d values (%0d out of range), checked %0d letters.",
			values_taken, bad_values, letters_seen);
		$display("Ran under random input gaps and output stalls, %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0 && numeral_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
sv/i2r_pkg.sv
sv/i2r_split.sv
sv/i2r_emit.sv
sv/integer_to_roman_numeral_top.sv
test/tb_integer_to_roman_numeral_top.sv
